/* src/mrfr_pkg.sv */
package mrfr_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CRC_W     = 16;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned HDR_DEPTH = 7;
  localparam int unsigned HDR_IDX_W = 3;
  localparam int unsigned MAX_FRAME = 128;
  localparam int unsigned MATCH_MIN = 9;

  localparam logic [CRC_W-1:0] CRC_START = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY  = 16'hA001;

  localparam logic [BYTE_W-1:0] RST_TIMEOUT    = 8'd20;
  localparam logic [BYTE_W-1:0] RST_ADDRESS    = 8'd1;
  localparam logic [BYTE_W-1:0] RST_FUNCTION   = 8'd3;
  localparam logic [BYTE_W-1:0] RST_BYTE_COUNT = 8'd4;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_TIMEOUT    = 2'd0;
  localparam cfg_idx_t CFG_ADDRESS    = 2'd1;
  localparam cfg_idx_t CFG_FUNCTION   = 2'd2;
  localparam cfg_idx_t CFG_BYTE_COUNT = 2'd3;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_EMPTY   = 2'd1,
    STATUS_CRC_ERR = 2'd2
  } status_t;

  // Modbus CRC-16, reflected, one byte folded in
  function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* src/mrfr_rx_if.sv */
interface mrfr_rx_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [mrfr_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

/* src/mrfr_res_if.sv */
interface mrfr_res_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    frame_status;
  logic [mrfr_pkg::BYTE_W-1:0]   frame_length;
  logic                          reply_match;
  logic [mrfr_pkg::WORD_W-1:0]   payload_word;

  modport source (output valid, output frame_status, output frame_length,
                  output reply_match, output payload_word, input ready);
  modport sink   (input valid, input frame_status, input frame_length,
                  input reply_match, input payload_word, output ready);
endinterface

/* src/modbus_rtu_frame_receiver.sv */
// An item is registered on transfer into the staging register and processed
// from there; a tick that ends a frame then loads the result register.
// Throughput: one item per cycle, as the CRC byte fold is combinational; a
// frame-ending tick waits while the result register holds an untaken result.
// Reset (rst, synchronous, active high) clears counters, CRC and handshake
// state and loads the register defaults; the header bytes are not cleared.
module modbus_rtu_frame_receiver (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_en,
  input  mrfr_pkg::cfg_idx_t                cfg_index,
  input  logic [mrfr_pkg::BYTE_W-1:0]       cfg_data,
  mrfr_rx_if.sink                           rx,
  mrfr_res_if.source                        res
);
  import mrfr_pkg::*;

  logic [BYTE_W-1:0] timeout_ticks;
  logic [BYTE_W-1:0] expected_address;
  logic [BYTE_W-1:0] expected_function;
  logic [BYTE_W-1:0] expected_byte_count;

  logic              st_valid;
  logic              st_kind;
  logic [BYTE_W-1:0] st_byte;

  logic [CRC_W-1:0]  crc;
  logic [CRC_W-1:0]  crc_next;
  logic [BYTE_W-1:0] byte_count;
  logic [BYTE_W-1:0] byte_count_next;
  logic [BYTE_W-1:0] silence_count;
  logic [BYTE_W-1:0] silence_count_next;
  logic [BYTE_W-1:0] header [HDR_DEPTH];
  logic              hdr_we;

  logic              out_valid;
  status_t           out_status;
  logic [BYTE_W-1:0] out_length;
  logic              out_match;
  logic [WORD_W-1:0] out_word;

  status_t           status_next;
  logic              match_next;
  logic [WORD_W-1:0] word_next;
  logic              emit;
  logic              out_free;
  logic              fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks       <= RST_TIMEOUT;
      expected_address    <= RST_ADDRESS;
      expected_function   <= RST_FUNCTION;
      expected_byte_count <= RST_BYTE_COUNT;
    end else if (cfg_en) begin
      case (cfg_index)
        CFG_TIMEOUT:    timeout_ticks       <= cfg_data;
        CFG_ADDRESS:    expected_address    <= cfg_data;
        CFG_FUNCTION:   expected_function   <= cfg_data;
        CFG_BYTE_COUNT: expected_byte_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // the staged item moves on unless it needs the result register and that is full
  assign out_free = !out_valid || res.ready;
  assign fire     = st_valid && (!emit || out_free);
  assign rx.ready = !st_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (rx.ready) begin
      st_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      st_kind <= rx.kind;
      st_byte <= rx.rx_byte;
    end
  end

  always_comb begin
    crc_next           = crc;
    byte_count_next    = byte_count;
    silence_count_next = silence_count;
    hdr_we             = 1'b0;
    emit               = 1'b0;
    status_next        = STATUS_CRC_ERR;
    match_next         = 1'b0;
    word_next          = '0;
    if (st_kind == KIND_BYTE) begin
      silence_count_next = '0;
      if (byte_count < BYTE_W'(MAX_FRAME)) begin
        hdr_we          = byte_count < BYTE_W'(HDR_DEPTH);
        byte_count_next = byte_count + 1'b1;
        crc_next        = crc_fold(crc, st_byte);
      end
    end else if (silence_count < timeout_ticks) begin
      silence_count_next = silence_count + 1'b1;
      if (silence_count_next == timeout_ticks) begin
        emit            = 1'b1;
        byte_count_next = '0;
        crc_next        = CRC_START;
        if (byte_count == '0) begin
          status_next = STATUS_EMPTY;
        end else if (crc == '0) begin
          status_next = STATUS_OK;
          if (byte_count >= BYTE_W'(HDR_DEPTH)) begin
            word_next = {header[3], header[4], header[5], header[6]};
          end
          match_next = (byte_count >= BYTE_W'(MATCH_MIN))
                    && (header[0] == expected_address)
                    && (header[1] == expected_function)
                    && (header[2] == expected_byte_count);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc           <= CRC_START;
      byte_count    <= '0;
      silence_count <= '0;
    end else if (fire) begin
      crc           <= crc_next;
      byte_count    <= byte_count_next;
      silence_count <= silence_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && hdr_we) begin
      header[byte_count[HDR_IDX_W-1:0]] <= st_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && emit) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_status <= status_next;
      out_length <= byte_count;
      out_match  <= match_next;
      out_word   <= word_next;
    end
  end

  assign res.valid        = out_valid;
  assign res.frame_status = out_status;
  assign res.frame_length = out_length;
  assign res.reply_match  = out_match;
  assign res.payload_word = out_word;

endmodule

/* src/mrfr_checker.sv */
module mrfr_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            res_valid,
  input logic                            res_ready,
  input logic [1:0]                      frame_status,
  input logic [mrfr_pkg::BYTE_W-1:0]     frame_length,
  input logic                            reply_match,
  input logic [mrfr_pkg::WORD_W-1:0]     payload_word
);
  import mrfr_pkg::*;

  // a pending result is not dropped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped before transfer");

  a_status: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (frame_status == STATUS_OK || frame_status == STATUS_EMPTY
                   || frame_status == STATUS_CRC_ERR))
    else $error("status code out of range");

  a_fields: assert property (@(posedge clk) disable iff (rst)
    res_valid && frame_status != STATUS_OK |-> !reply_match && payload_word == '0)
    else $error("match or payload set on a rejected frame");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (frame_status == STATUS_EMPTY) == (frame_length == '0))
    else $error("empty status disagrees with length");

  a_match: assert property (@(posedge clk) disable iff (rst)
    res_valid && reply_match |-> frame_length >= BYTE_W'(MATCH_MIN))
    else $error("reply match on a short frame");

endmodule

bind modbus_rtu_frame_receiver mrfr_checker u_mrfr_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .frame_status (res.frame_status),
  .frame_length (res.frame_length),
  .reply_match  (res.reply_match),
  .payload_word (res.payload_word)
);

/* bench/modbus_frame_checker.sv */
`timescale 1ns / 1ps

module modbus_frame_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_en,
  input  mrfr_pkg::cfg_idx_t          cfg_index,
  input  logic [mrfr_pkg::BYTE_W-1:0] cfg_data,
  mrfr_rx_if                          rx,
  mrfr_res_if                         res,
  output int                          errors,
  output int                          pending
);
  import mrfr_pkg::*;

  typedef struct packed {
    status_t             status;
    logic [BYTE_W-1:0]   len;
    logic                match;
    logic [WORD_W-1:0]   word;
  } frame_report_t;

  frame_report_t     frames_due[$];

  logic [BYTE_W-1:0] tmo_ticks, want_addr, want_fn, want_bc;
  logic [CRC_W-1:0]  crc_acc;
  logic [BYTE_W-1:0] stored;
  logic [BYTE_W-1:0] quiet_ticks;
  logic [BYTE_W-1:0] hdr [HDR_DEPTH];

  // bit-serial form: data bit i meets the register LSB at shift i
  function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] acc,
                                                   input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = acc;
    for (int i = 0; i < BYTE_W; i++) begin
      c = (c[0] ^ b[i]) ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    $display("%0t ns: %s mismatch, got %0h want %0h", $time, what, got, want);
    errors++;
  endtask

  task automatic take_event(input logic k, input logic [BYTE_W-1:0] b);
    frame_report_t r;
    if (k == KIND_BYTE) begin
      quiet_ticks = '0;
      // bytes past a full frame only reset the silence count
      if (stored < MAX_FRAME) begin
        if (stored < HDR_DEPTH) hdr[stored] = b;
        stored  = stored + 1'b1;
        crc_acc = crc16_byte(crc_acc, b);
      end
    end else if (quiet_ticks < tmo_ticks) begin
      quiet_ticks = quiet_ticks + 1'b1;
      if (quiet_ticks == tmo_ticks) begin
        r     = '0;
        r.len = stored;
        if (stored == 0) begin
          r.status = STATUS_EMPTY;
        end else if (crc_acc == '0) begin
          r.status = STATUS_OK;
          if (stored >= HDR_DEPTH) r.word = {hdr[3], hdr[4], hdr[5], hdr[6]};
          r.match = (stored >= MATCH_MIN) && (hdr[0] == want_addr) &&
                    (hdr[1] == want_fn) && (hdr[2] == want_bc);
        end else begin
          r.status = STATUS_CRC_ERR;
        end
        frames_due.push_back(r);
        stored  = '0;
        crc_acc = CRC_START;
      end
    end
  endtask

  always @(posedge clk) begin
    frame_report_t w;
    if (rst) begin
      tmo_ticks   = RST_TIMEOUT;
      want_addr   = RST_ADDRESS;
      want_fn     = RST_FUNCTION;
      want_bc     = RST_BYTE_COUNT;
      crc_acc     = CRC_START;
      stored      = '0;
      quiet_ticks = '0;
      frames_due.delete();
    end else begin
      if (cfg_en) begin
        case (cfg_index)
          CFG_TIMEOUT:    tmo_ticks = cfg_data;
          CFG_ADDRESS:    want_addr = cfg_data;
          CFG_FUNCTION:   want_fn   = cfg_data;
          CFG_BYTE_COUNT: want_bc   = cfg_data;
          default: ;
        endcase
      end
      if (rx.valid && rx.ready) take_event(rx.kind, rx.rx_byte);
      if (res.valid && res.ready) begin
        if (frames_due.size() == 0) begin
          report_mismatch("unexpected frame report", res.frame_length, '0);
        end else begin
          w = frames_due.pop_front();
          if (res.frame_status !== w.status)
            report_mismatch("frame_status", res.frame_status, w.status);
          if (res.frame_length !== w.len)
            report_mismatch("frame_length", res.frame_length, w.len);
          if (res.reply_match !== w.match)
            report_mismatch("reply_match", res.reply_match, w.match);
          if (res.payload_word !== w.word)
            report_mismatch("payload_word", res.payload_word, w.word);
        end
      end
    end
    pending <= frames_due.size();
  end

endmodule

/* bench/tb_modbus_rtu_frame_receiver.sv */
`timescale 1ns / 1ps

module tb_modbus_rtu_frame_receiver;
  import mrfr_pkg::*;

  typedef logic [BYTE_W-1:0] octet_q_t[$];

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1150;
  localparam int HOLD_CYCLES  = 400;

  logic              clk;
  logic              rst;
  logic              cfg_en;
  cfg_idx_t          cfg_index;
  logic [BYTE_W-1:0] cfg_data;

  mrfr_rx_if  rx();
  mrfr_res_if res();

  int errors;
  int pending;
  int cycles;
  int sent;
  bit quiet_tx, quiet_rx, hold_req;
  int cur_to, cur_addr, cur_fn, cur_bc;

  modbus_rtu_frame_receiver dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx        (rx),
    .res       (res)
  );

  modbus_frame_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .cfg_en    (cfg_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rx        (rx),
    .res       (res),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int w;
    bit held;
    held = 0;
    res.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_req && !held) begin
        held = 1;
        res.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        w = quiet_rx ? 0 : $urandom_range(0, 15);
        if (w > 0) begin
          res.ready <= 1'b0;
          repeat (w) @(posedge clk);
        end
      end
      res.ready <= 1'b1;
      do @(posedge clk); while (!res.valid);
      if ($urandom_range(0, 63) == 0) quiet_rx = !quiet_rx;
    end
  end

  task automatic put_item(input logic k, input logic [BYTE_W-1:0] b);
    int gap;
    gap = quiet_tx ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      rx.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx.valid   <= 1'b1;
    rx.kind    <= k;
    rx.rx_byte <= b;
    do @(posedge clk); while (!rx.ready);
    sent++;
    if ($urandom_range(0, 99) == 0) quiet_tx = !quiet_tx;
  endtask

  task automatic settle();
    rx.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    // a trailing byte or held tick gives no report; let it drain
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int v);
    cfg_en    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v[BYTE_W-1:0];
    @(posedge clk);
  endtask

  task automatic configure(input int to, input int a, input int f, input int c);
    cur_to   = to;
    cur_addr = a;
    cur_fn   = f;
    cur_bc   = c;
    write_reg(CFG_TIMEOUT, to);
    write_reg(CFG_ADDRESS, a);
    write_reg(CFG_FUNCTION, f);
    write_reg(CFG_BYTE_COUNT, c);
    cfg_en <= 1'b0;
  endtask

  // body, optional CRC (low byte first), optional single bit flip, then ticks
  task automatic send_frame(input octet_q_t body, input bit add_crc, input bit corrupt,
                            input int tail);
    octet_q_t         q;
    logic [CRC_W-1:0] crc;
    int               pos, lim;
    q = body;
    if (add_crc) begin
      crc = CRC_START;
      foreach (body[k]) crc = crc_fold(crc, body[k]);
      q.push_back(crc[7:0]);
      q.push_back(crc[15:8]);
    end
    if (corrupt && q.size() > 0) begin
      pos    = $urandom_range(0, q.size() - 1);
      q[pos] = q[pos] ^ (8'h01 << $urandom_range(0, 7));
    end
    lim = (cur_to > 4) ? 3 : cur_to - 1;
    foreach (q[k]) begin
      // short silence inside the frame, below the timeout
      if (k > 0 && lim > 0 && $urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, lim)) put_item(KIND_TICK, 8'($urandom));
      put_item(KIND_BYTE, q[k]);
    end
    repeat (tail) put_item(KIND_TICK, 8'($urandom));
  endtask

  initial begin
    octet_q_t body;
    int       goal, phase, phase_goal, sel, n, tail;
    rst       <= 1'b1;
    cfg_en    <= 1'b0;
    cfg_index <= CFG_TIMEOUT;
    cfg_data  <= '0;
    rx.valid  <= 1'b0;
    rx.kind   <= KIND_BYTE;
    rx.rx_byte <= '0;
    sent     = 0;
    quiet_tx = 0;
    quiet_rx = 0;
    hold_req = 0;
    cur_to   = RST_TIMEOUT;
    cur_addr = RST_ADDRESS;
    cur_fn   = RST_FUNCTION;
    cur_bc   = RST_BYTE_COUNT;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // ticks only after reset: one empty report, then the silence is held
    repeat (21) put_item(KIND_TICK, 8'($urandom));
    settle();

    configure(1, RST_ADDRESS, RST_FUNCTION, RST_BYTE_COUNT);
    body = '{8'h01, 8'h03, 8'h04, 8'hFF, 8'h00, 8'h80, 8'h7F};
    send_frame(body, 1, 0, 2);
    send_frame(body, 1, 1, 1);
    body.delete();
    send_frame(body, 1, 0, 1);
    body = '{8'h01, 8'h03, 8'h04, 8'hAA, 8'h55};
    send_frame(body, 1, 0, 1);
    body = '{8'h01, 8'h03, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00};
    send_frame(body, 1, 0, 1);
    body = '{8'h00, 8'hFF};
    send_frame(body, 0, 0, 1);
    // exactly a full frame with good CRC, then bytes past the limit
    body.delete();
    repeat (MAX_FRAME - 2) body.push_back(8'($urandom));
    send_frame(body, 1, 0, 0);
    repeat (3) put_item(KIND_BYTE, 8'($urandom));
    put_item(KIND_TICK, 8'($urandom));
    settle();

    goal  = sent + RANDOM_ITEMS;
    phase = 0;
    while (sent < goal) begin
      case (phase)
        0: configure(1, 0, 0, 0);
        1: configure(255, 255, 255, 255);
        default: configure($urandom_range(1, 6), $urandom_range(0, 255),
                           $urandom_range(0, 255),
                           $urandom_range(0, 1) ? 4 : $urandom_range(0, 255));
      endcase
      if (phase == 0) hold_req = 1;
      phase_goal = sent + 150;
      if (cur_to > 16) begin
        body = '{8'hFF, 8'hFF, 8'hFF, 8'h3F, 8'h80, 8'h00, 8'h01};
        send_frame(body, 1, 0, cur_to + 2);
      end else begin
        while (sent < phase_goal) begin
          body.delete();
          sel = $urandom_range(0, 99);
          if (sel < 45) begin
            // read reply shape, header mostly matching the current setting
            body.push_back(($urandom_range(0, 3) != 0) ? cur_addr[7:0] : 8'($urandom));
            body.push_back(($urandom_range(0, 3) != 0) ? cur_fn[7:0] : 8'($urandom));
            body.push_back(($urandom_range(0, 3) != 0) ? cur_bc[7:0] : 8'($urandom));
            n = (sel < 30) ? 4 : $urandom_range(0, 12);
          end else if (sel < 46) begin
            n = $urandom_range(118, 140);
          end else begin
            n = $urandom_range(0, 9);
          end
          repeat (n) body.push_back(8'($urandom));
          tail = ($urandom_range(0, 9) == 0) ? $urandom_range(0, cur_to - 1)
                                             : cur_to + $urandom_range(0, 2);
          send_frame(body, sel < 88, $urandom_range(0, 5) == 0, tail);
        end
      end
      settle();
      phase++;
    end

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
